// ===== rtl/core/lpcp_pkg.sv =====
// ----------------------------------------------------------------------------
// lpcp_pkg
// Shared types and constants for the lidar point to camera pixel projection.
// ----------------------------------------------------------------------------
package lpcp_pkg;

  // Input beat: one lidar point in signed millimetres
  typedef struct packed {
    logic signed [19:0] point_x;
    logic signed [19:0] point_y;
    logic signed [19:0] point_z;
  } point_t;

  // Output beat: point, visibility, pixel and tint
  typedef struct packed {
    logic signed [19:0] out_x;
    logic signed [19:0] out_y;
    logic signed [19:0] out_z;
    logic               visible;
    logic [9:0]         pixel_column;
    logic [8:0]         pixel_row;
    logic [7:0]         tint_green;
    logic [7:0]         tint_red;
  } result_t;

  // Register map, one 64-bit register every 8 bytes
  typedef enum logic [2:0] {
    REG_ROW0_A    = 3'd0,
    REG_ROW0_B    = 3'd1,
    REG_ROW1_A    = 3'd2,
    REG_ROW1_B    = 3'd3,
    REG_ROW2_A    = 3'd4,
    REG_ROW2_B    = 3'd5,
    REG_MIN_RANGE = 3'd6,
    REG_MAX_RANGE = 3'd7
  } reg_idx_t;

  localparam logic [19:0] MAX_RANGE_RESET = 20'd200000;

  // Tint reference distance (100 m) and its reciprocal for n / 100000
  localparam logic [16:0] TINT_REF_MM = 17'd100000;
  localparam logic [28:0] TINT_RECIP  = 29'd351843721;  // ceil(2^45 / 100000)
  localparam int          TINT_SHIFT  = 45;

endpackage

// ===== rtl/core/lidar_point_camera_projection.sv =====
// ----------------------------------------------------------------------------
// lidar_point_camera_projection
// Projects lidar points through a 3x4 Q16.16 matrix onto the image plane.
// ----------------------------------------------------------------------------
// Accepts one point per clock while the output is not stalled and returns
// one result per kept point, in order. The pipeline holds QW + 6 register
// stages, where QW = clog2(max(IMAGE_WIDTH, IMAGE_HEIGHT)). Depth is set by
// the long division for u/w and v/w, which resolves one quotient bit per
// stage. Points failing the azimuth gate (x >= |y|) produce no result. The
// whole pipeline advances whenever the output register is empty or being
// taken, so in_ready follows out_ready; configuration must only be written
// while no point is in flight.
module lidar_point_camera_projection
  import lpcp_pkg::*;
#(
  parameter int IMAGE_WIDTH  = 640,
  parameter int IMAGE_HEIGHT = 480
) (
  input  logic        clk,
  input  logic        rst_n,
  // point channel
  input  logic        in_valid,
  output logic        in_ready,
  input  point_t      in_data,
  // result channel
  output logic        out_valid,
  input  logic        out_ready,
  output result_t     out_data,
  // configuration
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [5:0]  cfg_paddr,
  input  logic [63:0] cfg_pwdata,
  output logic [63:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int MAX_DIM = (IMAGE_WIDTH > IMAGE_HEIGHT) ? IMAGE_WIDTH : IMAGE_HEIGHT;
  localparam int QW      = ($clog2(MAX_DIM) > 0) ? $clog2(MAX_DIM) : 1;
  localparam int NW      = 54;        // u, v, w width
  localparam int DW      = NW + QW;   // shifted divisor width

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [63:0] mat_r [6];
  logic [19:0] min_rng_r;
  logic [19:0] max_rng_r;
  logic        cfg_wr;
  reg_idx_t    cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite;
  assign cfg_idx    = reg_idx_t'(cfg_paddr[5:3]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 6; i++) mat_r[i] <= '0;
      min_rng_r <= '0;
      max_rng_r <= MAX_RANGE_RESET;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_ROW0_A:    mat_r[0]  <= cfg_pwdata;
        REG_ROW0_B:    mat_r[1]  <= cfg_pwdata;
        REG_ROW1_A:    mat_r[2]  <= cfg_pwdata;
        REG_ROW1_B:    mat_r[3]  <= cfg_pwdata;
        REG_ROW2_A:    mat_r[4]  <= cfg_pwdata;
        REG_ROW2_B:    mat_r[5]  <= cfg_pwdata;
        REG_MIN_RANGE: min_rng_r <= cfg_pwdata[19:0];
        REG_MAX_RANGE: max_rng_r <= cfg_pwdata[19:0];
        default:       ;
      endcase
    end
  end

  // register readback
  always_comb begin
    unique case (cfg_idx)
      REG_ROW0_A:    cfg_prdata = mat_r[0];
      REG_ROW0_B:    cfg_prdata = mat_r[1];
      REG_ROW1_A:    cfg_prdata = mat_r[2];
      REG_ROW1_B:    cfg_prdata = mat_r[3];
      REG_ROW2_A:    cfg_prdata = mat_r[4];
      REG_ROW2_B:    cfg_prdata = mat_r[5];
      REG_MIN_RANGE: cfg_prdata = {44'd0, min_rng_r};
      REG_MAX_RANGE: cfg_prdata = {44'd0, max_rng_r};
      default:       cfg_prdata = '0;
    endcase
  end

  // coefficients: coef[r][0..2] scale x,y,z; coef[r][3] is translation
  logic signed [31:0] coef [3][4];
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      coef[r][0] = $signed(mat_r[2*r][63:32]);
      coef[r][1] = $signed(mat_r[2*r][31:0]);
      coef[r][2] = $signed(mat_r[2*r+1][63:32]);
      coef[r][3] = $signed(mat_r[2*r+1][31:0]);
    end
  end

  // --------------------------------------------------------------------------
  // Pipeline advance: all stages move when the output slot frees up
  // --------------------------------------------------------------------------
  logic    adv;
  logic    out_valid_r;
  result_t out_data_r;

  assign adv      = !out_valid_r || out_ready;
  assign in_ready = adv;

  // --------------------------------------------------------------------------
  // Stage 1: azimuth gate, capture point
  // --------------------------------------------------------------------------
  logic signed [20:0] in_ay;
  logic               gate_ok;
  logic               v1_r;
  point_t             p1_r;

  assign in_ay   = in_data.point_y[19] ? -{in_data.point_y[19], in_data.point_y}
                                       :  {in_data.point_y[19], in_data.point_y};
  assign gate_ok = $signed({in_data.point_x[19], in_data.point_x}) >= in_ay;

  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else if (adv) v1_r <= in_valid && gate_ok;
  end
  always_ff @(posedge clk) begin
    if (adv) p1_r <= in_data;
  end

  // --------------------------------------------------------------------------
  // Stage 2: matrix products, squares, tint numerators
  // --------------------------------------------------------------------------
  logic signed [51:0] xyz_e  [3];
  logic signed [51:0] coef_e [3][3];
  logic signed [39:0] sq_e   [3];
  logic signed [20:0] xd;
  logic        [20:0] dabs;
  logic        [16:0] d17;

  always_comb begin
    xyz_e[0] = {{32{p1_r.point_x[19]}}, p1_r.point_x};
    xyz_e[1] = {{32{p1_r.point_y[19]}}, p1_r.point_y};
    xyz_e[2] = {{32{p1_r.point_z[19]}}, p1_r.point_z};
    for (int k = 0; k < 3; k++) sq_e[k] = xyz_e[k][39:0];
    for (int r = 0; r < 3; r++)
      for (int k = 0; k < 3; k++)
        coef_e[r][k] = {{20{coef[r][k][31]}}, coef[r][k]};
    xd   = $signed({p1_r.point_x[19], p1_r.point_x}) - $signed({4'd0, TINT_REF_MM});
    dabs = xd[20] ? 21'(-xd) : 21'(xd);
    d17  = dabs[16:0];
  end

  logic               v2_r;
  point_t             p2_r;
  logic signed [51:0] prod2_r [3][3];
  logic        [39:0] sq2_r   [3];
  logic        [39:0] mn2_r;
  logic        [39:0] mx2_r;
  logic               dlt2_r;
  logic        [24:0] ng2_r;
  logic        [24:0] nr2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v2_r <= 1'b0;
    else if (adv) v2_r <= v1_r;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      p2_r <= p1_r;
      for (int r = 0; r < 3; r++)
        for (int k = 0; k < 3; k++)
          prod2_r[r][k] <= coef_e[r][k] * xyz_e[k];
      for (int k = 0; k < 3; k++) sq2_r[k] <= 40'(sq_e[k] * sq_e[k]);
      mn2_r  <= {20'd0, min_rng_r} * {20'd0, min_rng_r};
      mx2_r  <= {20'd0, max_rng_r} * {20'd0, max_rng_r};
      dlt2_r <= dabs < {4'd0, TINT_REF_MM};
      ng2_r  <= 25'(d17) * 25'd255;
      nr2_r  <= 25'(TINT_REF_MM - d17) * 25'd255;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: row sums, range test, tint reciprocal multiply
  // --------------------------------------------------------------------------
  logic signed [NW-1:0] row_sum [3];
  logic        [41:0]   d2;

  always_comb begin
    for (int r = 0; r < 3; r++)
      row_sum[r] = NW'(prod2_r[r][0]) + NW'(prod2_r[r][1]) + NW'(prod2_r[r][2])
                 + NW'(coef[r][3]);
    d2 = 42'(sq2_r[0]) + 42'(sq2_r[1]) + 42'(sq2_r[2]);
  end

  logic                 v3_r;
  point_t               p3_r;
  logic signed [NW-1:0] uvw3_r [3];
  logic                 inr3_r;
  logic                 dlt3_r;
  logic        [53:0]   mg3_r;
  logic        [53:0]   mr3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v3_r <= 1'b0;
    else if (adv) v3_r <= v2_r;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      p3_r   <= p2_r;
      for (int r = 0; r < 3; r++) uvw3_r[r] <= row_sum[r];
      inr3_r <= (42'(mn2_r) < d2) && (d2 < 42'(mx2_r));
      dlt3_r <= dlt2_r;
      mg3_r  <= 54'(ng2_r) * 54'(TINT_RECIP);
      mr3_r  <= 54'(nr2_r) * 54'(TINT_RECIP);
    end
  end

  // --------------------------------------------------------------------------
  // Stage 4: make the divisor positive, finish tint
  // --------------------------------------------------------------------------
  logic                 v4_r;
  point_t               p4_r;
  logic signed [NW-1:0] nu4_r;
  logic signed [NW-1:0] nv4_r;
  logic        [NW-1:0] den4_r;
  logic                 ok4_r;
  logic        [7:0]    tg4_r;
  logic        [7:0]    tr4_r;
  logic                 wneg;

  assign wneg = uvw3_r[2][NW-1];

  always_ff @(posedge clk) begin
    if (!rst_n) v4_r <= 1'b0;
    else if (adv) v4_r <= v3_r;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      p4_r   <= p3_r;
      nu4_r  <= wneg ? -uvw3_r[0] : uvw3_r[0];
      nv4_r  <= wneg ? -uvw3_r[1] : uvw3_r[1];
      den4_r <= wneg ? NW'(-uvw3_r[2]) : NW'(uvw3_r[2]);
      ok4_r  <= inr3_r && (uvw3_r[2] != '0);
      tg4_r  <= dlt3_r ? mg3_r[TINT_SHIFT+7:TINT_SHIFT] : 8'hFF;
      tr4_r  <= dlt3_r ? mr3_r[TINT_SHIFT+7:TINT_SHIFT] : 8'h00;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 5 (division slot 0): sign and quotient overflow checks
  // Division slots 1..QW: one quotient bit each, MSB first
  // --------------------------------------------------------------------------
  logic             dv_r  [QW+1];
  logic             dok_r [QW+1];
  point_t           dp_r  [QW+1];
  logic [NW-1:0]    dden_r[QW+1];
  logic [DW-1:0]    dru_r [QW+1];
  logic [DW-1:0]    drv_r [QW+1];
  logic [QW-1:0]    dqu_r [QW+1];
  logic [QW-1:0]    dqv_r [QW+1];
  logic [7:0]       dtg_r [QW+1];
  logic [7:0]       dtr_r [QW+1];
  logic [DW-1:0]    den_top;

  assign den_top = DW'(den4_r) << QW;

  always_ff @(posedge clk) begin
    if (!rst_n) dv_r[0] <= 1'b0;
    else if (adv) dv_r[0] <= v4_r;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      dok_r[0]  <= ok4_r && !nu4_r[NW-1] && !nv4_r[NW-1]
                   && (DW'(nu4_r) < den_top) && (DW'(nv4_r) < den_top);
      dp_r[0]   <= p4_r;
      dden_r[0] <= den4_r;
      dru_r[0]  <= DW'(nu4_r);
      drv_r[0]  <= DW'(nv4_r);
      dqu_r[0]  <= '0;
      dqv_r[0]  <= '0;
      dtg_r[0]  <= tg4_r;
      dtr_r[0]  <= tr4_r;
    end
  end

  for (genvar k = 1; k <= QW; k++) begin : g_div
    localparam int BIT = QW - k;
    logic [DW-1:0] dsh;
    logic          ge_u;
    logic          ge_v;

    assign dsh  = DW'(dden_r[k-1]) << BIT;
    assign ge_u = dru_r[k-1] >= dsh;
    assign ge_v = drv_r[k-1] >= dsh;

    always_ff @(posedge clk) begin
      if (!rst_n) dv_r[k] <= 1'b0;
      else if (adv) dv_r[k] <= dv_r[k-1];
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        dok_r[k]  <= dok_r[k-1];
        dp_r[k]   <= dp_r[k-1];
        dden_r[k] <= dden_r[k-1];
        dru_r[k]  <= ge_u ? dru_r[k-1] - dsh : dru_r[k-1];
        drv_r[k]  <= ge_v ? drv_r[k-1] - dsh : drv_r[k-1];
        dqu_r[k]  <= dqu_r[k-1] | (QW'(ge_u) << BIT);
        dqv_r[k]  <= dqv_r[k-1] | (QW'(ge_v) << BIT);
        dtg_r[k]  <= dtg_r[k-1];
        dtr_r[k]  <= dtr_r[k-1];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Output register: image bounds, zero fields of hidden points
  // --------------------------------------------------------------------------
  logic vis;

  assign vis = dok_r[QW]
            && ({1'b0, dqu_r[QW]} < (QW+1)'(IMAGE_WIDTH))
            && ({1'b0, dqv_r[QW]} < (QW+1)'(IMAGE_HEIGHT));

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (adv) out_valid_r <= dv_r[QW];
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r.out_x        <= dp_r[QW].point_x;
      out_data_r.out_y        <= dp_r[QW].point_y;
      out_data_r.out_z        <= dp_r[QW].point_z;
      out_data_r.visible      <= vis;
      out_data_r.pixel_column <= vis ? 10'(dqu_r[QW]) : 10'd0;
      out_data_r.pixel_row    <= vis ? 9'(dqv_r[QW]) : 9'd0;
      out_data_r.tint_green   <= vis ? dtg_r[QW] : 8'd0;
      out_data_r.tint_red     <= vis ? dtr_r[QW] : 8'd0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== rtl/core/lpcp_checker.sv =====
// ----------------------------------------------------------------------------
// lpcp_checker
// Port-level checks for the lidar projection block, bound to the top level.
// ----------------------------------------------------------------------------
module lpcp_checker
  import lpcp_pkg::*;
(
  input logic    clk,
  input logic    rst_n,
  input logic    in_ready,
  input logic    out_valid,
  input logic    out_ready,
  input result_t out_data
);

  logic signed [20:0] out_ay;

  assign out_ay = out_data.out_y[19] ? -{out_data.out_y[19], out_data.out_y}
                                     :  {out_data.out_y[19], out_data.out_y};

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  // only points inside the azimuth gate come out
  a_gate: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $signed({out_data.out_x[19], out_data.out_x}) >= out_ay)
    else $error("result beat outside azimuth gate");

  // hidden points carry zero pixel and tint
  a_hidden_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.visible |-> out_data.pixel_column == 10'd0
      && out_data.pixel_row == 9'd0 && out_data.tint_green == 8'd0
      && out_data.tint_red == 8'd0)
    else $error("hidden point with nonzero pixel or tint");

  // a blocked output stalls the input side too
  a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("input accepted while output stalled");

endmodule

bind lidar_point_camera_projection lpcp_checker u_lpcp_checker (.*);

// ===== bench/projection_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// projection_checker
// Watches the point and result channels and the register port, keeps its own
// copy of the matrix and range registers, predicts one result per kept point
// and compares every result beat field by field in order.
// ----------------------------------------------------------------------------
module projection_checker
  import lpcp_pkg::*;
#(
  parameter int IMAGE_WIDTH  = 640,
  parameter int IMAGE_HEIGHT = 480
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  point_t      in_data,
  input  logic        out_valid,
  input  logic        out_ready,
  input  result_t     out_data,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [5:0]  cfg_paddr,
  input  logic [63:0] cfg_pwdata,
  output int          fail_count,
  output int          pending_count
);

  logic [63:0] matrix_reg [6];
  logic [19:0] min_range, max_range;
  result_t     expected_pixels [$];

  assign pending_count = expected_pixels.size();

  // One row of the projection: m0*x + m1*y + m2*z + m3
  function automatic longint project_row(int r, longint x, longint y, longint z);
    longint c0, c1, c2, c3;
    c0 = longint'($signed(matrix_reg[2*r][63:32]));
    c1 = longint'($signed(matrix_reg[2*r][31:0]));
    c2 = longint'($signed(matrix_reg[2*r+1][63:32]));
    c3 = longint'($signed(matrix_reg[2*r+1][31:0]));
    return c0 * x + c1 * y + c2 * z + c3;
  endfunction

  // Exact num/den in [0, lim); floor quotient on success
  function automatic bit pixel_in(longint num, longint den, longint lim,
                                  output longint q);
    q = 0;
    if (den < 0) begin
      num = -num;
      den = -den;
    end
    if (num < 0) return 0;
    q = num / den;
    return q < lim;
  endfunction

  // Build the expected beat for a point; returns 0 when the gate drops it
  function automatic bit project_point(point_t p, output result_t r);
    longint x, y, z, ay, u, v, w, col, row, d, g, rd;
    longint unsigned d2, mn2, mx2;
    bit vis;
    x = p.point_x;
    y = p.point_y;
    z = p.point_z;
    ay = (y < 0) ? -y : y;
    r = '0;
    if (x < ay) return 0;
    d2 = x * x + y * y + z * z;
    mn2 = longint'(min_range) * longint'(min_range);
    mx2 = longint'(max_range) * longint'(max_range);
    u = project_row(0, x, y, z);
    v = project_row(1, x, y, z);
    w = project_row(2, x, y, z);
    col = 0;
    row = 0;
    vis = mn2 < d2 && d2 < mx2 && w != 0 && pixel_in(u, w, IMAGE_WIDTH, col) &&
          pixel_in(v, w, IMAGE_HEIGHT, row);
    r.out_x = p.point_x;
    r.out_y = p.point_y;
    r.out_z = p.point_z;
    r.visible = vis;
    if (vis) begin
      d = x - 100000;
      if (d < 0) d = -d;
      g = 255 * d / 100000;
      if (g > 255) g = 255;
      rd = (d < 100000) ? 255 * (100000 - d) / 100000 : 0;
      r.pixel_column = col[9:0];
      r.pixel_row = row[8:0];
      r.tint_green = g[7:0];
      r.tint_red = rd[7:0];
    end
    return 1;
  endfunction

  always @(posedge clk) begin
    result_t exp_beat, got;
    if (!rst_n) begin
      for (int i = 0; i < 6; i++) matrix_reg[i] <= '0;
      min_range <= '0;
      max_range <= MAX_RANGE_RESET;
      fail_count <= 0;
      expected_pixels.delete();
    end else begin
      // register writes
      if (cfg_psel && cfg_penable && cfg_pwrite) begin
        case (reg_idx_t'(cfg_paddr[5:3]))
          REG_MIN_RANGE: min_range <= cfg_pwdata[19:0];
          REG_MAX_RANGE: max_range <= cfg_pwdata[19:0];
          default: matrix_reg[cfg_paddr[5:3]] <= cfg_pwdata;
        endcase
      end
      // point beat
      if (in_valid && in_ready && project_point(in_data, exp_beat))
        expected_pixels.insert(expected_pixels.size(), exp_beat);
      // result beat
      if (out_valid && out_ready) begin
        got = out_data;
        if (expected_pixels.size() == 0) begin
          $error("result beat with nothing expected: %h", got);
          fail_count <= fail_count + 1;
        end else begin
          exp_beat = expected_pixels.pop_front();
          if (got != exp_beat) begin
            fail_count <= fail_count + 1;
            if (got.out_x != exp_beat.out_x)
              $error("out_x exp %0d got %0d", exp_beat.out_x, got.out_x);
            if (got.out_y != exp_beat.out_y)
              $error("out_y exp %0d got %0d", exp_beat.out_y, got.out_y);
            if (got.out_z != exp_beat.out_z)
              $error("out_z exp %0d got %0d", exp_beat.out_z, got.out_z);
            if (got.visible != exp_beat.visible)
              $error("visible exp %0d got %0d", exp_beat.visible, got.visible);
            if (got.pixel_column != exp_beat.pixel_column)
              $error("pixel_column exp %0d got %0d", exp_beat.pixel_column,
                     got.pixel_column);
            if (got.pixel_row != exp_beat.pixel_row)
              $error("pixel_row exp %0d got %0d", exp_beat.pixel_row, got.pixel_row);
            if (got.tint_green != exp_beat.tint_green)
              $error("tint_green exp %0d got %0d", exp_beat.tint_green,
                     got.tint_green);
            if (got.tint_red != exp_beat.tint_red)
              $error("tint_red exp %0d got %0d", exp_beat.tint_red, got.tint_red);
          end
        end
      end
    end
  end

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives lidar points and register writes into the projection block.
// Several matrix and range settings are loaded; each phase sends a directed
// or random batch of points with random gaps and result back-pressure.
// ----------------------------------------------------------------------------
module testbench;
  import lpcp_pkg::*;

  localparam int DRAIN_CYCLES = 40;

  logic        clk;
  logic        rst_n;
  logic        in_valid, in_ready;
  point_t      in_data;
  logic        out_valid, out_ready;
  result_t     out_data;
  logic        cfg_psel, cfg_penable, cfg_pwrite, cfg_pready;
  logic [5:0]  cfg_paddr;
  logic [63:0] cfg_pwdata, cfg_prdata;
  int          fail_count, pending_count;
  bit          hold_sink;
  int          sink_hold_len;

  lidar_point_camera_projection dut (.*);

  projection_checker checker_i (.*);

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  // Gap length: mostly short, sometimes long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Result side stall pattern, with forced long hold-offs on request
  initial begin
    out_ready = 0;
    @(posedge clk iff rst_n);
    forever begin
      if (sink_hold_len > 0) begin
        out_ready <= 0;
        repeat (sink_hold_len) @(posedge clk);
        sink_hold_len = 0;
      end else if (hold_sink) begin
        out_ready <= 1;
        @(posedge clk);
      end else begin
        out_ready <= 1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
        if ($urandom_range(0, 2) == 0) begin
          out_ready <= 0;
          repeat (pick_gap() + 1) @(posedge clk);
        end
      end
    end
  end

  // One APB write, then the bus goes idle before the next transfer
  task automatic write_reg(reg_idx_t idx, logic [63:0] val);
    cfg_psel <= 1;
    cfg_penable <= 0;
    cfg_pwrite <= 1;
    cfg_paddr <= {idx, 3'b000};
    cfg_pwdata <= val;
    @(posedge clk);
    cfg_penable <= 1;
    @(posedge clk iff cfg_pready);
    cfg_psel <= 0;
    cfg_penable <= 0;
    cfg_pwrite <= 0;
    @(posedge clk);
  endtask

  task automatic send_point(logic signed [19:0] x, logic signed [19:0] y,
                            logic signed [19:0] z);
    int gap;
    in_valid <= 1;
    in_data <= '{x, y, z};
    @(posedge clk iff in_ready);
    if ($urandom_range(0, 3) == 0) begin
      gap = pick_gap();
      if (gap > 0) begin
        in_valid <= 0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic drain();
    in_valid <= 0;
    @(posedge clk iff pending_count == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [63:0] pack_pair(int a, int b);
    return {a[31:0], b[31:0]};
  endfunction

  // Calibration-like matrix: u ~ fu*y/x + cu, v ~ -fv*z/x + cv, w ~ x
  task automatic load_camera(int fu, int fv, int cu, int cv);
    write_reg(REG_ROW0_A, pack_pair(cu * 65536, fu * 65536));
    write_reg(REG_ROW0_B, pack_pair(0, $urandom_range(0, 2000) - 1000));
    write_reg(REG_ROW1_A, pack_pair(cv * 65536, 0));
    write_reg(REG_ROW1_B, pack_pair(-fv * 65536, $urandom_range(0, 2000) - 1000));
    write_reg(REG_ROW2_A, pack_pair(65536, 0));
    write_reg(REG_ROW2_B, pack_pair(0, 0));
  endtask

  // Random point, mostly in the forward gate
  task automatic random_point();
    int x, y, z;
    if ($urandom_range(0, 9) < 8) begin
      x = $urandom_range(0, $urandom_range(0, 1) ? 250000 : 524287);
      y = $urandom_range(0, x) * ($urandom_range(0, 1) ? 1 : -1);
      if (y < -524288) y = -524288;
      z = int'($urandom_range(0, 1048575)) - 524288;
      if ($urandom_range(0, 1)) z = z / 16;
    end else begin
      x = int'($urandom_range(0, 1048575)) - 524288;
      y = int'($urandom_range(0, 1048575)) - 524288;
      z = int'($urandom_range(0, 1048575)) - 524288;
    end
    send_point(20'(x), 20'(y), 20'(z));
  endtask

  initial begin
    rst_n = 0;
    in_valid = 0;
    in_data = '0;
    cfg_psel = 0;
    cfg_penable = 0;
    cfg_pwrite = 0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    hold_sink = 0;
    sink_hold_len = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // reset settings: zero matrix, so w is zero and nothing is visible
    send_point(0, 0, 0);
    send_point(1000, 0, 0);
    drain();

    // directed: extremes, gate edges, tint cases
    load_camera(500, 500, 320, 240);
    write_reg(REG_MIN_RANGE, 64'd0);
    write_reg(REG_MAX_RANGE, 64'hFFFFF);
    send_point(0, 0, 0);
    send_point(524287, 0, 0);
    send_point(524287, 524287, -524288);
    send_point(524287, -524287, 524287);
    send_point(-524288, -524288, -524288);
    send_point(100, 101, 0);
    send_point(100, -100, 0);
    send_point(100000, 0, 0);
    send_point(50000, 1000, -2000);
    send_point(199999, 0, 0);
    send_point(200001, 0, 0);
    send_point(1, 0, 0);
    send_point(10000, 6399, 4799);
    send_point(10000, -6401, -4801);
    send_point(10000, 6500, 0);
    send_point(20000, -3, 11);
    drain();

    // random phases over several settings; extremes of the range bounds
    for (int ph = 0; ph < 6; ph++) begin
      if (ph == 5) begin
        for (int i = 0; i < 6; i++)
          write_reg(reg_idx_t'(i), {$urandom(), $urandom()});
        write_reg(REG_MIN_RANGE, 64'hFFFFF);
        write_reg(REG_MAX_RANGE, 64'h0);
      end else begin
        load_camera($urandom_range(100, 1200), $urandom_range(100, 1200),
                    $urandom_range(0, 640), $urandom_range(0, 480));
        if (ph == 3) write_reg(REG_ROW2_B, pack_pair(0, 0));
        write_reg(REG_MIN_RANGE, (ph == 0) ? 64'd0 : $urandom_range(0, 20000));
        write_reg(REG_MAX_RANGE, (ph == 1) ? 64'hFFFFF : $urandom_range(50000, 1048575));
      end
      if (ph == 2) begin
        // stall the result side while the points keep coming
        sink_hold_len = 200;
        repeat (60) random_point();
      end
      repeat (300) random_point();
      drain();
    end
    // all-ones register values
    for (int i = 0; i < 8; i++) write_reg(reg_idx_t'(i), '1);
    repeat (20) random_point();
    drain();

    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("status: fail");
    $finish;
  end

endmodule
